[rtl/bmff_pkg.sv]
// Package for the bit map with find-first-set and find-first-clear.
// Holds command codes, the scan token type and shared helpers.
// No dependencies.
`default_nettype none

package bmff_pkg;

  // default size of the bit map
  localparam int MaxBitsDef = 256;

  // width of the bit count register
  localparam int CfgW = 9;

  // reset value of the bit count
  localparam logic [CfgW-1:0] BitCountRst = 9'd256;

  // command codes, the unused code acts as test
  localparam logic [1:0] CMD_SET  = 2'd0;
  localparam logic [1:0] CMD_CLR  = 2'd1;
  localparam logic [1:0] CMD_TEST = 2'd2;

  // payload widths
  localparam int InDataW  = 16;
  localparam int OutDataW = 24;

  // scan token handed from cell to cell
  typedef struct packed {
    logic       valid;
    logic       ok;
    logic [4:0] byte_sel;
    logic [2:0] bit_sel;
    logic       bit_value;
    logic       set_found;
    logic [7:0] first_set;
    logic       clear_found;
    logic [7:0] first_clear;
  } tok_t;

  // store update broadcast to all cells
  typedef struct packed {
    logic       we;
    logic       value;
    logic [4:0] byte_sel;
    logic [2:0] bit_sel;
  } upd_t;

  // position of the lowest one in a byte
  function automatic logic [2:0] lowest_one(input logic [7:0] bits);
    logic [2:0] pos;
    pos = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (bits[k]) begin
        pos = 3'(k);
      end
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

[rtl/bmff_cell.sv]
// One cell of the bit map chain: holds one byte of the store, applies
// updates and folds its byte into the passing scan token.
// Depends on bmff_pkg.
`default_nettype none

module bmff_cell
  import bmff_pkg::*;
#(
  parameter int MAX_BITS = MaxBitsDef,
  parameter int CELL_IDX = 0
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire upd_t                  upd_i,
  input  wire logic [
    (($clog2(MAX_BITS+1) > CfgW) ? $clog2(MAX_BITS+1) : CfgW)-1:0] vb_i,
  input  wire tok_t                  tok_i,
  output tok_t                       tok_o
);

  localparam int VbW = $clog2(MAX_BITS + 1);
  localparam int CW  = (VbW > CfgW) ? VbW : CfgW;
  localparam logic [4:0] CellLo = 5'(CELL_IDX % 32);
  localparam bit Addressable = (CELL_IDX < 32);

  logic [7:0] byte_q, byte_d;
  tok_t       tok_q, tok_d;
  logic [7:0] mask;
  logic [7:0] set_bits, clr_bits;
  logic       upd_hit, tok_hit;

  // valid-bit mask for this byte
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      mask[k] = (CW'(CELL_IDX * 8 + k) < vb_i);
    end
  end

  assign upd_hit = Addressable && (upd_i.byte_sel == CellLo);
  assign tok_hit = Addressable && (tok_i.byte_sel == CellLo);

  // store update
  always_comb begin
    byte_d = byte_q;
    if (upd_i.we && upd_hit) begin
      byte_d[upd_i.bit_sel] = upd_i.value;
    end
  end

  // fold this byte into the token
  assign set_bits = byte_q & mask;
  assign clr_bits = ~byte_q & mask;

  always_comb begin
    tok_d = tok_i;
    if (tok_i.ok && tok_hit) begin
      tok_d.bit_value = byte_q[tok_i.bit_sel];
    end
    if (!tok_i.set_found && (|set_bits)) begin
      tok_d.set_found = 1'b1;
      tok_d.first_set = {CellLo, lowest_one(set_bits)};
    end
    if (!tok_i.clear_found && (|clr_bits)) begin
      tok_d.clear_found = 1'b1;
      tok_d.first_clear = {CellLo, lowest_one(clr_bits)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
      tok_q  <= '0;
    end else begin
      byte_q <= byte_d;
      tok_q  <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

[rtl/bit_map_find_first.sv]
// Bit map with find-first-set and find-first-clear, built as a chain of
// byte cells. Depends on bmff_pkg and bmff_cell.
//
// Usage:
//   Input stream s_axis: each transfer carries a command (set, clear,
//   test) and a bit index. The bit is changed if the index is below the
//   bit count; the result reports whether the index was in range, the
//   addressed bit after the operation, and the lowest set and lowest
//   clear bit among the valid bits, each with a found flag.
//   Output stream m_axis: one result transfer per input transfer.
//   Configuration: cfg_we_i writes cfg_wdata_i into the bit count; write
//   it only while no item is in flight.
//   Timing: the update happens at the input transfer, then a scan token
//   is registered and passes through the register of every cell in turn
//   before the result is registered at the output. A new item is taken
//   only after the previous item's token has left the last cell.
//   Reset clears every bit of the map and sets the bit count to 256.
//   A stalled receiver: the result waits in the output register, a second
//   finished result waits in a skid register, and s_axis_tready stays low
//   until that register drains.
`default_nettype none

module bit_map_find_first
  import bmff_pkg::*;
#(
  parameter int MAX_BITS = MaxBitsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration
  input  wire logic                cfg_we_i,
  input  wire logic [CfgW-1:0]     cfg_wdata_i,
  // input stream
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // [1:0] cmd, [9:2] bit_index, [15:10] zero
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // output stream
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [0] ok, [1] bit_value, [2] set_found, [10:3] first_set,
  // [11] clear_found, [19:12] first_clear, [23:20] zero
  output logic [OutDataW-1:0]      m_axis_tdata
);

  localparam int NumCells = (MAX_BITS + 7) / 8;
  localparam int VbW      = $clog2(MAX_BITS + 1);
  localparam int CW       = (VbW > CfgW) ? VbW : CfgW;

  logic [CfgW-1:0] bit_count_q;
  logic [CW-1:0]   bc_ext, vb;
  logic [1:0]      cmd;
  logic [7:0]      bit_index;
  logic            in_ok, in_xfer, out_free, arrive;
  upd_t            upd;
  tok_t            inj_q, inj_d;
  tok_t            chain [NumCells+1];
  tok_t            last_tok;
  logic            busy_q;
  logic            skid_v_q;
  tok_t            skid_q;
  logic            out_v_q;
  tok_t            out_q;

  // bit count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_count_q <= BitCountRst;
    end else if (cfg_we_i) begin
      bit_count_q <= cfg_wdata_i;
    end
  end

  // effective bit count, saturated to the map size
  assign bc_ext = CW'(bit_count_q);
  assign vb     = (bc_ext > CW'(MAX_BITS)) ? CW'(MAX_BITS) : bc_ext;

  // input decode
  assign cmd       = s_axis_tdata[1:0];
  assign bit_index = s_axis_tdata[9:2];
  assign in_ok     = (CW'(bit_index) < vb);
  assign s_axis_tready = !busy_q && !skid_v_q;
  assign in_xfer   = s_axis_tvalid && s_axis_tready;

  // store update broadcast
  always_comb begin
    upd.byte_sel = bit_index[7:3];
    upd.bit_sel  = bit_index[2:0];
    upd.value    = 1'b0;
    upd.we       = 1'b0;
    unique case (cmd)
      CMD_SET: begin
        upd.value = 1'b1;
        upd.we    = in_xfer && in_ok;
      end
      CMD_CLR: begin
        upd.we    = in_xfer && in_ok;
      end
      default: begin
        upd.we    = 1'b0;
      end
    endcase
  end

  // scan token, registered and launched in the cycle after the transfer
  always_comb begin
    inj_d             = '0;
    inj_d.valid       = in_xfer;
    inj_d.ok          = in_ok;
    inj_d.byte_sel    = bit_index[7:3];
    inj_d.bit_sel     = bit_index[2:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inj_q <= '0;
    end else begin
      inj_q <= inj_d;
    end
  end

  assign chain[0] = inj_q;

  // chain of byte cells
  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    bmff_cell #(
      .MAX_BITS (MAX_BITS),
      .CELL_IDX (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .upd_i  (upd),
      .vb_i   (vb),
      .tok_i  (chain[g]),
      .tok_o  (chain[g+1])
    );
  end

  assign last_tok = chain[NumCells];
  assign arrive   = last_tok.valid;
  assign out_free = !out_v_q || m_axis_tready;

  // item in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (in_xfer) begin
      busy_q <= 1'b1;
    end else if (arrive) begin
      busy_q <= 1'b0;
    end
  end

  // output register and skid register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (out_free) begin
        if (skid_v_q) begin
          out_v_q  <= 1'b1;
          skid_v_q <= 1'b0;
        end else begin
          out_v_q  <= arrive;
        end
      end else if (arrive) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_v_q) begin
        out_q <= skid_q;
      end else if (arrive) begin
        out_q <= last_tok;
      end
    end else if (arrive) begin
      skid_q <= last_tok;
    end
  end

  // result packing
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {4'd0, out_q.first_clear, out_q.clear_found, out_q.first_set,
                          out_q.set_found, out_q.ok & out_q.bit_value, out_q.ok};

endmodule

`default_nettype wire
